// ===== hdl/ipoc_pkg.sv =====
// ipoc_pkg: shared constants and codes for the interval peak overlap counter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ipoc_pkg;
   localparam int MAX_ITEMS_DEF = 64;
   localparam int DATE_W = 31;
   localparam int STATUS_W = 2;
   localparam int PEAK_W = 7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ORDER    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;
endpackage
`default_nettype wire

// ===== hdl/ipoc_store.sv =====
// ipoc_store: the two date memories, one write port and one shared read address
// depends on ipoc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ipoc_store #(
   parameter int MAX_ITEMS = ipoc_pkg::MAX_ITEMS_DEF,
   parameter int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [ipoc_pkg::DATE_W-1:0] wr_eval,
   input  wire logic [ipoc_pkg::DATE_W-1:0] wr_earliest,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [ipoc_pkg::DATE_W-1:0] rd_eval,
   output logic      [ipoc_pkg::DATE_W-1:0] rd_earliest
);
   logic [ipoc_pkg::DATE_W-1:0] eval_mem [MAX_ITEMS];
   logic [ipoc_pkg::DATE_W-1:0] earliest_mem [MAX_ITEMS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         eval_mem[wr_addr] <= wr_eval;
         earliest_mem[wr_addr] <= wr_earliest;
      end
   end

   // registered read, data appears in the cycle after the address
   always_ff @(posedge clock) begin
      rd_eval <= eval_mem[rd_addr];
      rd_earliest <= earliest_mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/interval_peak_overlap_counter.sv =====
// Loads a list of (evaluation, earliest) date pairs, one word per cycle while req_ready is
// high, into two on-chip memories. After the word flagged last, it reports status and the
// peak number of overlapping intervals. Error lists answer on the cycle after the last
// word. A clean list of n pairs is scanned as n passes over the memory read port, one per
// pair, run one after another since the date memories have a single read port. Load runs
// at one word per cycle while req_ready is high; no word is taken during a scan.
// depends on ipoc_pkg and ipoc_store
`timescale 1ns / 1ps
`default_nettype none
module interval_peak_overlap_counter #(
   parameter int MAX_ITEMS = ipoc_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ipoc_pkg::DATE_W-1:0]   req_eval_date,
   input  wire logic [ipoc_pkg::DATE_W-1:0]   req_earliest_date,
   input  wire logic                          req_last_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ipoc_pkg::STATUS_W-1:0] rsp_status,
   output logic      [ipoc_pkg::PEAK_W-1:0]   rsp_peak_count
);
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = CW + 1;

   typedef enum logic [2:0] {
      ST_LOAD, ST_RD_I, ST_LATCH_I, ST_SCAN, ST_DRAIN
   } state_type;

   state_type                     state_ff;
   logic [CW-1:0]                 count_ff;
   logic                          order_ff;
   logic                          ovfl_ff;
   logic [AW-1:0]                 i_ff;
   logic [AW-1:0]                 j_ff;
   logic [ipoc_pkg::DATE_W-1:0]   evi_ff;
   logic signed [SW-1:0]          score_ff;
   logic signed [SW-1:0]          peak_ff;
   logic                          d_vld_ff;
   logic                          d_last_ff;
   logic                          rsp_valid_ff;
   ipoc_pkg::status_type          status_ff;
   logic [ipoc_pkg::PEAK_W-1:0]   peak_out_ff;

   logic                          accept;
   logic                          full;
   logic                          order_in;
   logic [AW-1:0]                 last_idx;
   logic [AW-1:0]                 rd_addr;
   logic [ipoc_pkg::DATE_W-1:0]   rd_eval;
   logic [ipoc_pkg::DATE_W-1:0]   rd_earliest;
   logic signed [SW-1:0]          score_in;

   // handshake and load bookkeeping
   assign req_ready = (state_ff == ST_LOAD) && (!rsp_valid_ff || !req_last_item);
   assign accept = req_valid && req_ready;
   assign full = (count_ff == CW'(MAX_ITEMS));
   assign order_in = req_earliest_date > req_eval_date;
   assign last_idx = AW'(count_ff - CW'(1));
   assign rd_addr = (state_ff == ST_RD_I) ? i_ff : j_ff;

   // running count: evals at or above the pivot minus earliests strictly above it
   always_comb begin
      score_in = score_ff;
      if (rd_eval >= evi_ff) score_in = score_in + SW'(1);
      if (rd_earliest > evi_ff) score_in = score_in - SW'(1);
   end

   ipoc_store #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_store (
      .clock      (clock),
      .wr_en      (accept && !full),
      .wr_addr    (AW'(count_ff)),
      .wr_eval    (req_eval_date),
      .wr_earliest(req_earliest_date),
      .rd_addr    (rd_addr),
      .rd_eval    (rd_eval),
      .rd_earliest(rd_earliest)
   );

   // control sequence and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         order_ff <= 1'b0;
         ovfl_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         d_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         score_ff <= '0;
         peak_ff <= '0;
         status_ff <= ipoc_pkg::STATUS_OK;
         peak_out_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         d_vld_ff <= (state_ff == ST_SCAN);
         d_last_ff <= (state_ff == ST_SCAN) && (j_ff == last_idx);
         if (d_vld_ff) score_ff <= score_in;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (req_last_item) begin
                     if (ovfl_ff || full) begin
                        rsp_valid_ff <= 1'b1;
                        status_ff <= ipoc_pkg::STATUS_OVERFLOW;
                        peak_out_ff <= '0;
                        count_ff <= '0;
                     end else if (order_ff || order_in) begin
                        rsp_valid_ff <= 1'b1;
                        status_ff <= ipoc_pkg::STATUS_ORDER;
                        peak_out_ff <= '0;
                        count_ff <= '0;
                     end else begin
                        count_ff <= count_ff + CW'(1);
                        i_ff <= '0;
                        peak_ff <= '0;
                        state_ff <= ST_RD_I;
                     end
                     order_ff <= 1'b0;
                     ovfl_ff <= 1'b0;
                  end else begin
                     if (!full) count_ff <= count_ff + CW'(1);
                     if (order_in) order_ff <= 1'b1;
                     if (full) ovfl_ff <= 1'b1;
                  end
               end
            end
            ST_RD_I: begin
               state_ff <= ST_LATCH_I;
            end
            ST_LATCH_I: begin
               evi_ff <= rd_eval;
               score_ff <= '0;
               j_ff <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               j_ff <= j_ff + AW'(1);
               if (j_ff == last_idx) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (d_last_ff) begin
                  if (score_in > peak_ff) peak_ff <= score_in;
                  if (i_ff == last_idx) begin
                     rsp_valid_ff <= 1'b1;
                     status_ff <= ipoc_pkg::STATUS_OK;
                     peak_out_ff <= (score_in > peak_ff) ? ipoc_pkg::PEAK_W'(score_in)
                                                         : ipoc_pkg::PEAK_W'(peak_ff);
                     count_ff <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     i_ff <= i_ff + AW'(1);
                     state_ff <= ST_RD_I;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_peak_count = peak_out_ff;

`ifndef NO_ASSERTIONS
   // an error result never carries a peak
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ipoc_pkg::STATUS_OK) |-> rsp_peak_count == '0)
      else $error("error result with nonzero peak");
   // no words are taken while the scan runs
   a_no_load_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_ready)
      else $error("ready during scan");
   // fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("fill count overrun");
   // a finished scan always lands a result
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) && d_last_ff && (i_ff == last_idx) |=> rsp_valid)
      else $error("scan end without result");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for interval_peak_overlap_counter
// depends on ipoc_pkg and the counter rtl; directed table then random lists
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int NMAX = ipoc_pkg::MAX_ITEMS_DEF;
   localparam int DATE_W = ipoc_pkg::DATE_W;
   localparam int STATUS_W = ipoc_pkg::STATUS_W;
   localparam int PEAK_W = ipoc_pkg::PEAK_W;
   localparam int WATCHDOG = 200000;
   localparam logic [DATE_W-1:0] DMAX = {DATE_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DATE_W-1:0] req_eval_date = '0;
   logic [DATE_W-1:0] req_earliest_date = '0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PEAK_W-1:0] rsp_peak_count;

   interval_peak_overlap_counter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_eval_date(req_eval_date), .req_earliest_date(req_earliest_date),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_peak_count(rsp_peak_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PEAK_W-1:0]   peak;
   } peak_result_type;

   // directed row: dates, last flag, and an optional typed-in answer
   typedef struct {
      logic [DATE_W-1:0]    ev;
      logic [DATE_W-1:0]    er;
      bit                   last;
      bit                   fixed;
      ipoc_pkg::status_type status;
      logic [PEAK_W-1:0]    peak;
   } row_type;

   peak_result_type expected_results[$];
   logic [DATE_W-1:0] list_ev[$];
   logic [DATE_W-1:0] list_er[$];
   bit list_order_bad = 0;
   bit list_overflow = 0;

   int mismatches = 0;
   int lists_done = 0;
   int words_sent = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit quiet_in = 0;
   bit quiet_out = 0;
   bit hold_off = 0;

   // peak overlap of the stored list: sort both sides, walk from the top
   function automatic logic [PEAK_W-1:0] overlap_peak();
      logic [DATE_W-1:0] ev_s[$];
      logic [DATE_W-1:0] er_s[$];
      int ei, ri, open, best;
      ev_s = list_ev;
      er_s = list_er;
      ev_s.sort();
      er_s.sort();
      ei = ev_s.size();
      ri = er_s.size();
      open = 0;
      best = 0;
      while (ei > 0) begin
         if (ri == 0 || ev_s[ei-1] >= er_s[ri-1]) begin
            open++;
            if (open > best) best = open;
            ei--;
         end else begin
            open--;
            ri--;
         end
      end
      return best[PEAK_W-1:0];
   endfunction

   // account for one accepted word, queue a result at the end of a list
   function automatic void absorb_word(logic [DATE_W-1:0] ev, logic [DATE_W-1:0] er,
                                       bit last);
      peak_result_type r;
      if (er > ev) list_order_bad = 1;
      if (list_ev.size() < NMAX) begin
         list_ev.push_back(ev);
         list_er.push_back(er);
      end else begin
         list_overflow = 1;
      end
      if (last) begin
         r.peak = '0;
         if (list_overflow) r.status = ipoc_pkg::STATUS_OVERFLOW;
         else if (list_order_bad) r.status = ipoc_pkg::STATUS_ORDER;
         else begin
            r.status = ipoc_pkg::STATUS_OK;
            r.peak = overlap_peak();
         end
         expected_results.push_back(r);
         list_ev.delete();
         list_er.delete();
         list_order_bad = 0;
         list_overflow = 0;
      end
   endfunction

   // offer one word and wait for it to be taken
   task automatic send_word(logic [DATE_W-1:0] ev, logic [DATE_W-1:0] er, bit last);
      while (!quiet_in && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_eval_date <= ev;
      req_earliest_date <= er;
      req_last_item <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_word(ev, er, last);
      words_sent++;
      @(negedge clock);
   endtask

   // stop offering words until every expected result has come
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock);
      while (expected_results.size() != 0 && !timed_out);
   endtask

   // random list: mostly well ordered, a few order errors, sizes mostly small
   task automatic send_random_list();
      int n, k, span;
      logic [DATE_W-1:0] a, b, base;
      bit allow_bad;
      k = $urandom_range(99);
      if (k < 4) n = NMAX + int'($urandom_range(3));
      else if (k < 8) n = NMAX - int'($urandom_range(1));
      else n = int'($urandom_range(1, 8));
      allow_bad = ($urandom_range(99) < 10);
      span = ($urandom_range(1)) ? 20 : 0;
      base = DATE_W'($urandom());
      for (int i = 0; i < n; i++) begin
         if (span != 0) begin
            a = DATE_W'(base + $urandom_range(span));
            b = DATE_W'(base + $urandom_range(span));
         end else begin
            a = DATE_W'($urandom());
            b = DATE_W'($urandom());
         end
         if (!allow_bad && b > a) begin
            a ^= b; b ^= a; a ^= b;
         end
         send_word(a, b, i == n - 1);
      end
   endtask

   // result side: random stalls, a long hold-off on request
   initial begin
      int wait_left;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            wait_left = 400;
            while (wait_left > 0) begin
               @(negedge clock);
               wait_left--;
            end
            hold_off = 0;
         end
         rsp_ready <= quiet_out || ($urandom_range(99) >= 14);
         @(negedge clock);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      peak_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result status=%0d peak=%0d", rsp_status, rsp_peak_count);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_status !== exp_r.status || rsp_peak_count !== exp_r.peak) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status exp %0d got %0d, peak exp %0d got %0d",
                           exp_r.status, rsp_status, exp_r.peak, rsp_peak_count);
            end
            lists_done++;
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("tb_top NOT OK");
         $finish;
      end
   end

   row_type rows[$];
   peak_result_type fixed_r;

   initial begin
      // directed lists: extremes, equality overlap, order error, both errors
      rows = '{
         '{DMAX, '0, 1'b1, 1'b1, ipoc_pkg::STATUS_OK, 7'd1},
         '{'0, '0, 1'b1, 1'b1, ipoc_pkg::STATUS_OK, 7'd1},
         '{'0, DMAX, 1'b1, 1'b1, ipoc_pkg::STATUS_ORDER, 7'd0},
         '{31'd10, 31'd5, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd20, 31'd10, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd15, 31'd15, 1'b1, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd5, 31'd1, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd10, 31'd5, 1'b1, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'h2AAAAAAA, 31'h15555555, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'h55555555, 31'h2AAAAAAA, 1'b1, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd7, 31'd3, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd2, 31'd9, 1'b0, 1'b0, ipoc_pkg::STATUS_OK, 7'd0},
         '{31'd8, 31'd8, 1'b1, 1'b1, ipoc_pkg::STATUS_ORDER, 7'd0}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_word(rows[i].ev, rows[i].er, rows[i].last);
         if (rows[i].fixed) begin
            // overwrite the predicted value with the one typed in
            fixed_r.status = rows[i].status;
            fixed_r.peak = rows[i].peak;
            expected_results[expected_results.size()-1] = fixed_r;
         end
      end
      // overflow with an order error too: status must read list too long
      for (int i = 0; i <= NMAX; i++)
         send_word(DATE_W'(i), (i == 3) ? DMAX : '0, i == NMAX);
      // a full store of identical intervals gives the widest peak
      for (int i = 0; i < NMAX; i++) send_word(DMAX, '0, i == NMAX - 1);
      drain_results();

      // random lists, with a quiet stretch and back-pressure phases
      while (words_sent < 1200 && !timed_out) begin
         if (lists_done > 30 && lists_done < 40) begin
            quiet_in = 1; quiet_out = 1;
         end else begin
            quiet_in = 0; quiet_out = 0;
         end
         if ($urandom_range(49) == 0) hold_off = 1;
         send_random_list();
         if ($urandom_range(9) == 0) drain_results();
      end
      hold_off = 1;
      for (int i = 0; i < 4; i++) send_word(DATE_W'(i + 1), '0, i == 3);
      drain_results();
      repeat (50) @(negedge clock);

      $display("covered %0d words in %0d lists, incl. a full store and overflow",
               words_sent, lists_done);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
